// File: hw/rtl/nta_pkg.sv
package nta_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int MAX_DIGITS      = 10;
  localparam int HEX_DIGITS      = 8;

  // divide by ten: q = (x * 0xCCCCCCCD) >> 35, exact for any 32-bit x
  localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT = 35;
  localparam int          QUOT_W      = 64 - DIV10_SHIFT;

  localparam logic [1:0] CMD_DEC = 2'd0;
  localparam logic [1:0] CMD_HEX = 2'd1;
  localparam logic [1:0] CMD_PCT = 2'd2;

  localparam logic [6:0] CH_ZERO    = 7'h30;
  localparam logic [6:0] CH_X       = 7'h78;
  localparam logic [6:0] CH_DOT     = 7'h2E;
  localparam logic [6:0] CH_PERCENT = 7'h25;
  localparam logic [6:0] CH_A       = 7'h41;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [6:0] character;
    logic       last;
  } out_beat_t;

  // what the character selector needs from the sequencer
  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] pos;
    logic [3:0] ndig;
  } emit_ctl_t;

endpackage

// File: hw/rtl/number_to_ascii_formatter_core.sv
// channel | beat fields          | handshake
// in      | command[1:0], value  | in_valid / in_ready
// out     | character[6:0], last | out_valid / out_ready
//
// Decimal/percent: each decimal digit takes a multiply and a remainder step on
// the shared divide-by-ten multiplier, then one character per cycle unless
// out_ready stalls. Hex: 10 characters. Command 3 is taken and dropped.
// in_ready is high only while idle; the last character may still sit in the
// output register then. A stalled out_ready freezes character emission.
// Reset (rst_n low, synchronous) clears the sequencer and output valid.
module number_to_ascii_formatter_core #(
  parameter int VALUE_WIDTH = nta_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  nta_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output nta_pkg::out_beat_t out_data
);
  import nta_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_REM  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]                  state_r, state_nxt;
  logic [1:0]                  mode_r, mode_nxt;
  logic [3:0]                  pos_r, pos_nxt;
  logic [3:0]                  ndig_r, ndig_nxt;
  logic [VALUE_WIDTH-1:0]      val_r, val_nxt;
  logic [MAX_DIGITS-1:0][3:0]  dig_r, dig_nxt;
  logic                        out_valid_r, out_valid_nxt;
  out_beat_t                   out_data_r, out_data_nxt;

  logic [VALUE_WIDTH-1:0]      in_val;
  logic [QUOT_W-1:0]           quot;
  logic [3:0]                  rem;
  logic                        div_load;
  emit_ctl_t                   ctl;
  out_beat_t                   beat;
  logic                        slot_free;

  nta_div10 u_div10 (
    .clk       (clk),
    .load      (div_load),
    .dividend  (32'(val_r)),
    .quotient  (quot),
    .remainder (rem)
  );

  assign ctl.mode = mode_r;
  assign ctl.pos  = pos_r;
  assign ctl.ndig = ndig_r;

  nta_charsel #(.VALUE_WIDTH(VALUE_WIDTH)) u_charsel (
    .ctl    (ctl),
    .digits (dig_r),
    .value  (val_r),
    .beat   (beat)
  );

  assign in_val    = in_data.value[VALUE_WIDTH-1:0];
  assign in_ready  = (state_r == ST_IDLE);
  assign div_load  = (state_r == ST_MUL);
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    pos_nxt       = pos_r;
    ndig_nxt      = ndig_r;
    val_nxt       = val_r;
    dig_nxt       = dig_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          val_nxt  = in_val;
          pos_nxt  = '0;
          ndig_nxt = '0;
          dig_nxt  = '0;
          // zero in percent mode prints a bare '0'
          mode_nxt = (in_data.command == CMD_PCT && in_val == '0) ? CMD_DEC
                                                                  : in_data.command;
          if (in_data.command == CMD_HEX) begin
            state_nxt = ST_EMIT;
          end else if (in_data.command == CMD_DEC || in_data.command == CMD_PCT) begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        state_nxt = ST_REM;
      end
      ST_REM: begin
        dig_nxt[ndig_r] = rem;
        ndig_nxt        = ndig_r + 4'd1;
        val_nxt         = VALUE_WIDTH'(quot);
        if (quot == '0) begin
          state_nxt = ST_EMIT;
          // one-digit percent pads to ".0d"
          if (mode_r == CMD_PCT && ndig_r == 4'd0) begin
            ndig_nxt = 4'd2;
          end
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = beat;
          pos_nxt       = pos_r + 4'd1;
          if (beat.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    pos_r      <= pos_nxt;
    ndig_r     <= ndig_nxt;
    val_r      <= val_nxt;
    dig_r      <= dig_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hw/rtl/nta_div10.sv
module nta_div10 (
  input  logic                      clk,
  input  logic                      load,
  input  logic [31:0]               dividend,
  output logic [nta_pkg::QUOT_W-1:0] quotient,
  output logic [3:0]                remainder
);
  import nta_pkg::*;

  logic [QUOT_W-1:0] q_r;
  logic [63:0]       prod;
  logic [31:0]       diff;

  assign prod = 64'(dividend) * 64'(DIV10_RECIP);

  always_ff @(posedge clk) begin
    if (load) begin
      q_r <= QUOT_W'(prod >> DIV10_SHIFT);
    end
  end

  // dividend is held by the caller until the remainder is taken
  assign diff      = dividend - (32'(q_r) << 3) - (32'(q_r) << 1);
  assign quotient  = q_r;
  assign remainder = diff[3:0];

endmodule

// File: hw/rtl/nta_charsel.sv
module nta_charsel #(
  parameter int VALUE_WIDTH = nta_pkg::VALUE_WIDTH_DEF
) (
  input  nta_pkg::emit_ctl_t                        ctl,
  input  logic [nta_pkg::MAX_DIGITS-1:0][3:0]       digits,
  input  logic [VALUE_WIDTH-1:0]                    value,
  output nta_pkg::out_beat_t                        beat
);
  import nta_pkg::*;

  logic [31:0] val32;
  logic [2:0]  nib_idx;
  logic [3:0]  nib;
  logic [6:0]  hex_ch;
  logic [3:0]  msb_pos;
  logic [3:0]  dig_idx;
  logic [3:0]  dig;

  assign val32   = 32'(value);
  assign nib_idx = 3'(4'd9 - ctl.pos);
  assign nib     = val32[4*nib_idx +: 4];
  assign hex_ch  = (nib > 4'd9) ? (CH_A + 7'(nib - 4'd10)) : (CH_ZERO + 7'(nib));

  // digits are stored least significant first
  always_comb begin
    msb_pos = ctl.pos;
    if (ctl.mode == CMD_PCT && ctl.pos > ctl.ndig - 4'd2) begin
      msb_pos = ctl.pos - 4'd1;
    end
    dig_idx = ctl.ndig - 4'd1 - msb_pos;
    dig     = digits[dig_idx];
  end

  always_comb begin
    beat.character = CH_ZERO + 7'(dig);
    beat.last      = 1'b0;
    case (ctl.mode)
      CMD_HEX: begin
        if (ctl.pos == 4'd0) begin
          beat.character = CH_ZERO;
        end else if (ctl.pos == 4'd1) begin
          beat.character = CH_X;
        end else begin
          beat.character = hex_ch;
        end
        beat.last = (ctl.pos == 4'(HEX_DIGITS + 1));
      end
      CMD_PCT: begin
        if (ctl.pos == ctl.ndig + 4'd1) begin
          beat.character = CH_PERCENT;
          beat.last      = 1'b1;
        end else if (ctl.pos == ctl.ndig - 4'd2) begin
          beat.character = CH_DOT;
        end
      end
      default: begin
        beat.last = (ctl.pos == ctl.ndig - 4'd1);
      end
    endcase
  end

endmodule

// File: hw/rtl/nta_checker.sv
module nta_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input nta_pkg::in_beat_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input nta_pkg::out_beat_t out_data
);
  import nta_pkg::*;

  // a held output beat keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // only digits, hex letters, 'x', '.' and '%' are ever produced
  a_charset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.character >= CH_ZERO && out_data.character <= 7'h39) ||
                  (out_data.character >= CH_A && out_data.character <= 7'h46) ||
                  out_data.character == CH_X || out_data.character == CH_DOT ||
                  out_data.character == CH_PERCENT)
    else $error("unexpected character");

  // '%' always closes the text
  a_pct_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.character == CH_PERCENT |-> out_data.last)
    else $error("percent sign not marked last");

  // a valid command keeps the block busy in the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.command == CMD_DEC || in_data.command == CMD_HEX ||
                             in_data.command == CMD_PCT) |=> !in_ready)
    else $error("ready right after taking a command");

endmodule

bind number_to_ascii_formatter_core nta_checker u_nta_checker (.*);
